@@ src/pstd_pkg.sv @@
package pstd_pkg;

  localparam int WordW  = 32;
  localparam int MagW   = 24;
  localparam int ManW   = 53;
  localparam int ProdW  = 60;
  localparam int ExpW   = 12;
  localparam int DigW   = 4;
  localparam int NumDig = ProdW / DigW;
  localparam int ExpBias = 1075;

  localparam int SignPos  = 31;
  localparam int DirPos   = 30;
  localparam int FactPos  = 26;
  localparam int CountLsb = 27;
  localparam int CountMsb = 29;

  localparam logic [6:0] Factor10  = 7'd10;
  localparam logic [6:0] Factor100 = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic rnd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic dir_mul;
    logic div_last;
  } status_t;

endpackage

@@ src/packed_sample_to_double.sv @@
// Decodes a 32-bit packed sample into an IEEE-754 double bit pattern. A request is taken
// when start is high and busy is low; its result appears on double_bits for exactly one
// cycle with done high, and must be captured then. Each multiply step is one registered
// multiply and one rounding step; each divide step runs a divide-by-ten loop that
// produces one 4-bit quotient digit per cycle. A new request may be started in the
// cycle in which done is high.
module packed_sample_to_double (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pstd_pkg::WordW-1:0] packed_word,
  output logic                       busy,
  output logic                       done,
  output logic [63:0]                double_bits
);
  import pstd_pkg::*;

  cmd_t    cmd;
  status_t status;

  pstd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pstd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .packed_word (packed_word),
    .status      (status),
    .double_bits (double_bits),
    .done        (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

@@ src/pstd_ctrl.sv @@
module pstd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pstd_pkg::status_t status,
  output pstd_pkg::cmd_t    cmd,
  output logic              busy
);
  import pstd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.stop) begin
          state_next = ST_FINISH;
        end else if (status.dir_mul) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ROUND;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.rnd = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        cmd.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pstd_datapath.sv @@
module pstd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pstd_pkg::cmd_t                cmd,
  input  logic [pstd_pkg::WordW-1:0]    packed_word,
  output pstd_pkg::status_t             status,
  output logic [63:0]                   double_bits,
  output logic                          done
);
  import pstd_pkg::*;

  logic [ManW-1:0]  mant;
  logic [ExpW-1:0]  expo;
  logic [2:0]       cnt;
  logic             sign;
  logic             dir_mul;
  logic             fac100;
  logic             zero;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] dvd;
  logic [3:0]       rem;
  logic [3:0]       dig;

  logic [MagW-1:0]  mag;
  logic [4:0]       lz;
  logic [5:0]       norm_sh;

  logic [7:0]       part;
  logic [15:0]      qmul;
  logic [3:0]       qd;
  logic [7:0]       qten;

  logic [2:0]       sh;
  logic [ProdW-1:0] kept;
  logic             guard;
  logic             sticky;
  logic [ManW:0]    rsum;
  logic [ExpW-1:0]  exp_adj;
  logic [ExpW-1:0]  exp_biased;

  assign mag = packed_word[MagW-1:0];

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < MagW; i++) begin
      if (mag[i]) begin
        lz = 5'(MagW - 1 - i);
      end
    end
  end

  assign norm_sh = 6'(ManW - MagW) + 6'(lz);

  // one radix-16 digit of the divide by ten
  assign part = {rem, dvd[ProdW-1 -: DigW]};
  assign qmul = 16'(part) * 16'd205;
  assign qd   = qmul[14:11];
  assign qten = 8'(qd) * 8'd10;

  always_comb begin
    if (dir_mul && fac100) begin
      sh = prod[59] ? 3'd7 : 3'd6;
    end else begin
      sh = prod[56] ? 3'd4 : 3'd3;
    end
    kept   = prod >> sh;
    guard  = |(prod & (ProdW'(1) << (sh - 3'd1)));
    sticky = |(prod & ((ProdW'(1) << (sh - 3'd1)) - ProdW'(1)))
           | (!dir_mul && (rem != 4'd0));
    rsum   = kept[ManW:0] + (ManW+1)'(guard && (sticky || kept[0]));
    if (dir_mul) begin
      exp_adj = ExpW'(sh);
    end else begin
      exp_adj = ExpW'(sh) - ExpW'(7);
    end
  end

  assign status.stop     = zero || (cnt == 3'd0);
  assign status.dir_mul  = dir_mul;
  assign status.div_last = (dig == 4'(NumDig - 1));

  assign exp_biased = expo + ExpW'(ExpBias);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sign    <= packed_word[SignPos];
      dir_mul <= packed_word[DirPos];
      fac100  <= packed_word[FactPos];
      cnt     <= packed_word[CountMsb:CountLsb];
      zero    <= (mag == '0);
      mant    <= ManW'(mag) << norm_sh;
      expo    <= -ExpW'(norm_sh);
    end
    if (cmd.mul) begin
      prod <= ProdW'(mant) * ProdW'(fac100 ? Factor100 : Factor10);
    end
    if (cmd.div_init) begin
      dvd  <= {mant, 7'b0};
      rem  <= '0;
      dig  <= '0;
      prod <= '0;
    end
    if (cmd.div_step) begin
      dvd  <= dvd << DigW;
      prod <= {prod[ProdW-DigW-1:0], qd};
      rem  <= 4'(part - qten);
      dig  <= dig + 4'd1;
    end
    if (cmd.rnd) begin
      cnt <= cnt - 3'd1;
      if (rsum[ManW]) begin
        mant <= rsum[ManW:1];
        expo <= expo + exp_adj + ExpW'(1);
      end else begin
        mant <= rsum[ManW-1:0];
        expo <= expo + exp_adj;
      end
    end
    if (cmd.emit) begin
      if (zero) begin
        double_bits <= {sign, 63'b0};
      end else begin
        double_bits <= {sign, exp_biased[10:0], mant[51:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

@@ tb/tb_packed_sample_to_double.sv @@
`timescale 1ns / 1ps

module tb_packed_sample_to_double;
  import pstd_pkg::*;

  localparam int CycleLimit = 2000000;

  logic             clk;
  logic             rst;
  logic             start;
  logic [WordW-1:0] packed_word;
  logic             busy;
  logic             done;
  logic [63:0]      double_bits;

  logic [63:0] expected_doubles[$];
  int          mismatches;
  int          requests_sent;
  int          results_checked;
  int          cycle_count;

  packed_sample_to_double dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .packed_word(packed_word),
    .busy(busy),
    .done(done),
    .double_bits(double_bits)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // decode one packed sample into its binary64 pattern
  function automatic logic [63:0] decode_sample(input logic [WordW-1:0] w);
    real         v;
    real         factor;
    int          steps;
    logic [63:0] bits;
    if (w == '0) return 64'd0;
    factor = w[FactPos] ? 100.0 : 10.0;
    steps = int'(w[CountMsb:CountLsb]);
    v = real'(w[MagW-1:0]);
    for (int i = 0; i < steps; i++) begin
      if (w[DirPos]) v = v * factor;
      else v = v / 10.0;
    end
    bits = $realtobits(v);
    if (w[SignPos]) bits[63] = ~bits[63];
    return bits;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch: %s got %h expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("packed_sample_to_double test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && done) begin
      if (expected_doubles.size() == 0) begin
        report_mismatch("unexpected result", double_bits, 64'd0);
      end else begin
        want = expected_doubles.pop_front();
        results_checked++;
        if (double_bits !== want) report_mismatch("double_bits", double_bits, want);
      end
    end
  end

  // called at a falling edge; leaves start high on return
  task automatic send_request(input logic [WordW-1:0] w);
    start <= 1'b1;
    packed_word <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    expected_doubles.push_back(decode_sample(w));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    packed_word <= $urandom();
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (expected_doubles.size() != 0) @(negedge clk);
  endtask

  function automatic logic [WordW-1:0] make_word(input bit sgn, input bit dir,
                                                 input int cnt, input bit fact,
                                                 input logic [MagW-1:0] mag);
    logic [WordW-1:0] w;
    w = $urandom();
    w[SignPos] = sgn;
    w[DirPos] = dir;
    w[CountMsb:CountLsb] = cnt[2:0];
    w[FactPos] = fact;
    w[MagW-1:0] = mag;
    return w;
  endfunction

  task automatic test_special_words();
    send_request(32'h0000_0000);
    send_request(32'h8000_0000);
    send_request(make_word(1'b1, 1'b1, 7, 1'b1, '0));
    send_request(make_word(1'b1, 1'b0, 5, 1'b0, '0));
    send_request(32'hffff_ffff);
    send_request(32'h7fff_ffff);
    send_request(32'h0300_0000);
    send_request(32'h0000_0001);
    send_request(32'h00ff_ffff);
    drain_results();
  endtask

  task automatic test_every_scaling();
    for (int c = 0; c < 8; c++) begin
      send_request(make_word(c[0], 1'b1, c, 1'b0, MagW'($urandom())));
      send_request(make_word(c[1], 1'b1, c, 1'b1, '1));
      send_request(make_word(c[2], 1'b0, c, c[0], MagW'($urandom())));
    end
    drain_results();
  endtask

  task automatic test_random_bursts(input int total);
    int               burst;
    logic [WordW-1:0] w;
    while (total > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && total > 0; i++) begin
        case ($urandom_range(0, 3))
          0: w = $urandom();
          1: w = make_word(1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 7),
                           1'($urandom_range(0, 1)), MagW'($urandom()));
          2: w = make_word(1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 7),
                           1'($urandom_range(0, 1)), MagW'($urandom_range(0, 255)));
          default: w = make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 1) ? '1 : MagW'($urandom_range(0, 3)));
        endcase
        send_request(w);
        total--;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
      if ($urandom_range(0, 30) == 0) drain_results();
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    start = 1'b0;
    packed_word = '0;
    mismatches = 0;
    requests_sent = 0;
    results_checked = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    idle_cycles(2);
    test_special_words();
    test_every_scaling();
    test_random_bursts(1200);
    drain_results();
    waited = 0;
    while (waited < 200) begin
      @(negedge clk);
      waited++;
    end
    $display("sent %0d packed samples, checked %0d doubles across all signs, directions,",
             requests_sent, results_checked);
    $display("factors and step counts with bursty requests");
    if (mismatches == 0 && expected_doubles.size() == 0) begin
      $display("packed_sample_to_double test passed");
    end else begin
      $display("packed_sample_to_double test failed");
    end
    $finish;
  end

endmodule
